// File: rtl/tune_event_decoder_defines.svh
// assertion macros shared by the tune event decoder files
`ifndef TUNE_EVENT_DECODER_DEFINES_SVH
`define TUNE_EVENT_DECODER_DEFINES_SVH

`ifndef SYNTH
`define TED_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tune event decoder assertion failed");
`define TED_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tune event decoder assertion failed");
`else
`define TED_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define TED_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/ted_pkg.sv
`default_nettype none

package ted_pkg;

  typedef enum logic [1:0] {
    KIND_EXTEND = 2'd0,
    KIND_REST   = 2'd1,
    KIND_NOTE   = 2'd2,
    KIND_END    = 2'd3
  } ted_kind_t;

  typedef struct packed {
    logic [7:0] duration_byte;
    logic [7:0] pitch_byte;
  } ted_in_t;

  typedef struct packed {
    ted_kind_t   event_kind;
    logic [15:0] duration_ms;
    logic [11:0] frequency_hz;
    logic [7:0]  gap_ms;
    logic        last;
  } ted_out_t;

  localparam int unsigned MAX_PAIRS = 62;

  // divider geometry: dividend bits, divisor bits, two quotient bits per step
  localparam int unsigned DIV_W     = 34;
  localparam int unsigned DVS_W     = 17;
  localparam int unsigned DIV_STEPS = DIV_W / 2;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

  localparam logic [DVS_W-1:0] LEN_DIVISOR  = 17'd11000;
  localparam logic [DIV_W-1:0] FREQ_DIVIDEND = 34'd10000000;
  localparam logic [7:0]       DUR_EXTEND   = 8'd255;
  localparam logic [7:0]       GAP_MIN      = 8'd239;

  typedef struct packed {
    logic load;
    logic mul;
    logic div_start;
    logic div_sel_freq;
    logic cap_len;
    logic cap_freq;
    logic out_load;
  } ted_cmd_t;

  typedef struct packed {
    logic in_note;
    logic div_done;
  } ted_status_t;

endpackage

`default_nettype wire

// File: rtl/ted_div.sv
`default_nettype none
`include "tune_event_decoder_defines.svh"

module ted_div (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        start,
  input  wire [ted_pkg::DIV_W-1:0]   dividend,
  input  wire [ted_pkg::DVS_W-1:0]   divisor,
  output logic                       done,
  output logic [ted_pkg::DIV_W-1:0]  quotient
);
  import ted_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [DVS_W-1:0]     dvs_r;
  logic [DVS_W-1:0]     rem_r, rem_nxt;
  logic [DIV_W-1:0]     quo_r, quo_nxt;

  // two restoring steps per cycle; quo_r shifts dividend out, quotient in
  always_comb begin
    logic [DVS_W:0]   t;
    logic [DVS_W-1:0] r;
    logic [DIV_W-1:0] q;
    r = rem_r;
    q = quo_r;
    for (int i = 0; i < 2; i++) begin
      t = {r, q[DIV_W-1]};
      q = {q[DIV_W-2:0], 1'b0};
      if (t >= {1'b0, dvs_r}) begin
        t = t - {1'b0, dvs_r};
        q[0] = 1'b1;
      end
      r = t[DVS_W-1:0];
    end
    rem_nxt = r;
    quo_nxt = q;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == CNT_W'(DIV_STEPS - 1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
        end
        cnt_r <= cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvs_r <= divisor;
      rem_r <= '0;
      quo_r <= dividend;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

  `TED_ASSERT_NXT(a_div_start_busy, clk, rst_n, start, busy_r)
  `TED_ASSERT_IMP(a_div_done_idle, clk, rst_n, done_r, !busy_r)

endmodule

`default_nettype wire

// File: rtl/ted_dp.sv
`default_nettype none
`include "tune_event_decoder_defines.svh"

module ted_dp (
  input  wire                    clk,
  input  wire                    rst_n,
  input  ted_pkg::ted_cmd_t      cmd,
  output ted_pkg::ted_status_t   status,
  input  ted_pkg::ted_in_t       in_data,
  input  wire                    cfg_we,
  input  wire [7:0]              cfg_data,
  output ted_pkg::ted_out_t      out_data
);
  import ted_pkg::*;

  logic [7:0]        gap_setting_r;
  logic [7:0]        ext_cnt_r;
  logic [7:0]        pair_cnt_r;
  ted_kind_t         kind_r;
  logic [15:0]       total_r;
  logic [DVS_W-1:0]  period_r;
  logic [DIV_W-1:0]  prod_r;
  logic [15:0]       len_r;
  logic [11:0]       freq_r;
  logic [7:0]        gap_r;
  logic              last_r;
  ted_out_t          out_r;

  logic              is_end, is_ext, is_rest;
  logic [15:0]       total;
  logic [DVS_W-1:0]  period;
  logic [3:0]        gap_steps;
  logic [7:0]        gap;
  logic              hit_limit;
  ted_kind_t         kind;
  logic [DIV_W-1:0]  div_dividend;
  logic [DVS_W-1:0]  div_divisor;
  logic              div_done;
  logic [DIV_W-1:0]  div_quo;

  assign is_end  = (in_data.duration_byte == 8'd0) && (in_data.pitch_byte == 8'd0);
  assign is_ext  = (in_data.duration_byte == DUR_EXTEND) && (in_data.pitch_byte != 8'd0);
  assign is_rest = (in_data.pitch_byte == 8'd0);

  // ext*255 + dur
  assign total  = {ext_cnt_r, 8'd0} - {8'd0, ext_cnt_r} + {8'd0, in_data.duration_byte};
  assign period = DVS_W'(in_data.pitch_byte) * DVS_W'(247) + DVS_W'(4000);

  // 10 * (255 - setting), only when the setting is above 239
  assign gap_steps = 4'(DUR_EXTEND - gap_setting_r);
  assign gap       = (gap_setting_r > GAP_MIN) ?
                     ({1'b0, gap_steps, 3'b000} + {3'b000, gap_steps, 1'b0}) : 8'd0;

  assign hit_limit = ({1'b0, pair_cnt_r} + 9'd1) >= 9'(MAX_PAIRS);

  always_comb begin
    priority if (is_end) begin
      kind = KIND_END;
    end else if (is_ext) begin
      kind = KIND_EXTEND;
    end else if (is_rest) begin
      kind = KIND_REST;
    end else begin
      kind = KIND_NOTE;
    end
  end

  assign status.in_note  = (kind == KIND_NOTE);
  assign status.div_done = div_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_setting_r <= '0;
      ext_cnt_r     <= '0;
      pair_cnt_r    <= '0;
    end else begin
      if (cfg_we) begin
        gap_setting_r <= cfg_data;
      end
      if (cmd.load) begin
        if (is_end || hit_limit) begin
          ext_cnt_r  <= '0;
          pair_cnt_r <= '0;
        end else begin
          pair_cnt_r <= pair_cnt_r + 8'd1;
          ext_cnt_r  <= is_ext ? ext_cnt_r + 8'd1 : 8'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r   <= kind;
      total_r  <= total;
      period_r <= period;
      len_r    <= (kind == KIND_REST) ? total : 16'd0;
      freq_r   <= '0;
      gap_r    <= is_end ? 8'd0 : gap;
      last_r   <= is_end || hit_limit;
    end
    if (cmd.mul) begin
      prod_r <= {1'b0, 33'(total_r) * 33'(period_r)};
    end
    if (cmd.cap_len) begin
      len_r <= div_quo[15:0];
    end
    if (cmd.cap_freq) begin
      freq_r <= div_quo[11:0];
    end
    if (cmd.out_load) begin
      out_r.event_kind   <= kind_r;
      out_r.duration_ms  <= len_r;
      out_r.frequency_hz <= freq_r;
      out_r.gap_ms       <= gap_r;
      out_r.last         <= last_r;
    end
  end

  assign div_dividend = cmd.div_sel_freq ? FREQ_DIVIDEND : prod_r;
  assign div_divisor  = cmd.div_sel_freq ? period_r : LEN_DIVISOR;

  ted_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign out_data = out_r;

  // a pair that ends the tune leaves the pair count at zero, any other one does not
  `TED_ASSERT_NXT(a_dp_last_count, clk, rst_n, cmd.load, last_r == (pair_cnt_r == 8'd0))
  `TED_ASSERT_NXT(a_dp_ext_clear, clk, rst_n, cmd.load && !is_ext, ext_cnt_r == 8'd0)

endmodule

`default_nettype wire

// File: rtl/ted_ctrl.sv
`default_nettype none
`include "tune_event_decoder_defines.svh"

module ted_ctrl (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire                   out_ready,
  input  ted_pkg::ted_status_t  status,
  output ted_pkg::ted_cmd_t     cmd
);
  import ted_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_LEN_GO,
    ST_DIV_LEN,
    ST_DIV_FREQ,
    ST_WRITE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = status.in_note ? ST_MUL : ST_WRITE;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_LEN_GO;
      end
      ST_LEN_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIV_LEN;
      end
      ST_DIV_LEN: begin
        if (status.div_done) begin
          // length quotient ready, reuse the divider for the frequency
          cmd.cap_len      = 1'b1;
          cmd.div_start    = 1'b1;
          cmd.div_sel_freq = 1'b1;
          state_nxt        = ST_DIV_FREQ;
        end
      end
      ST_DIV_FREQ: begin
        cmd.div_sel_freq = 1'b1;
        if (status.div_done) begin
          cmd.cap_freq = 1'b1;
          state_nxt    = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;

  `TED_ASSERT_NXT(a_ctrl_out_load, clk, rst_n, cmd.out_load, out_valid_r)
  `TED_ASSERT_IMP(a_ctrl_div_start, clk, rst_n, cmd.div_start,
                  state_r == ST_LEN_GO || state_r == ST_DIV_LEN)

endmodule

`default_nettype wire

// File: rtl/tune_event_decoder.sv
// flow: extend, rest and end pairs go from ST_IDLE straight to ST_WRITE; a note pair first
// passes ST_MUL, ST_LEN_GO, ST_DIV_LEN and ST_DIV_FREQ; ST_WRITE waits while a result is untaken
// a new pair is accepted only in ST_IDLE, after the last result is loaded; a note runs two
// 34-bit divisions, 17 radix-4 steps each, on one shared divider
// reset: synchronous active-low rst_n clears the pair and extension counts,
// the gap setting and the controller; the result register drops its valid
`default_nettype none

module tune_event_decoder (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_ready,
  input  ted_pkg::ted_in_t   in_data,
  output logic               out_valid,
  input  wire                out_ready,
  output ted_pkg::ted_out_t  out_data,
  input  wire                cfg_valid,
  output logic               cfg_ready,
  input  wire [7:0]          cfg_data
);
  import ted_pkg::*;

  ted_cmd_t    cmd;
  ted_status_t status;

  assign cfg_ready = 1'b1;

  ted_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  ted_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .status   (status),
    .in_data  (in_data),
    .cfg_we   (cfg_valid),
    .cfg_data (cfg_data),
    .out_data (out_data)
  );

endmodule

`default_nettype wire
